@@ src/pscd_pkg.sv @@
// ----------------------------------------------------------------------------
// pscd_pkg
// Shared types and constants of the provisioning cost datapath.
// ----------------------------------------------------------------------------
package pscd_pkg;

  localparam int unsigned CostW = 32;
  localparam int unsigned NeedW = 8;
  localparam int unsigned CfgW  = 40;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [CostW-1:0] cost_t;
  typedef logic [NeedW-1:0] need_t;

  localparam cost_t CostSat = '1;
  localparam need_t NeedSat = '1;

  localparam logic [CfgIdxW-1:0] CfgCpuStep  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMemStep  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCpuFloor = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMemFloor = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMaxCount = 3'd4;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_RELAX,
    CELL_COMMIT,
    CELL_FIRST,
    CELL_MLOAD,
    CELL_MIN
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e mode;
    need_t      lo;
    need_t      limit;
  } cell_ctrl_t;

  function automatic cost_t sat_inc(cost_t x);
    return (x == CostSat) ? CostSat : x + cost_t'(1);
  endfunction

  function automatic cost_t cost_min(cost_t a, cost_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

@@ src/pscd_div.sv @@
// ----------------------------------------------------------------------------
// pscd_div
// Bit-serial restoring divider giving one container need, clamped to 255.
// ----------------------------------------------------------------------------
module pscd_div #(
  parameter int unsigned W = 40
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [W-1:0]      dividend_i,
  input  logic [W-1:0]      divisor_i,
  output logic              busy_o,
  output pscd_pkg::need_t   need_o
);
  import pscd_pkg::*;

  localparam int unsigned CntW = $clog2(W + 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W:0]      rem_q, rem_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [W-1:0]    div_q, div_d;
  logic [W:0]      trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    trial  = {rem_q[W-1:0], quo_q[W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(W);
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = trial - {1'b0, div_q};
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  always_comb begin
    if (div_q == '0) begin
      need_o = NeedSat;
    end else if (quo_q >= W'(NeedSat)) begin
      need_o = NeedSat;
    end else begin
      need_o = need_t'(quo_q) + need_t'(1);
    end
  end

  assign busy_o = busy_q;

endmodule

@@ src/pscd_cell.sv @@
// ----------------------------------------------------------------------------
// pscd_cell
// One count of the cost row: holds the cost and relaxes distances with
// its neighbors.
// ----------------------------------------------------------------------------
module pscd_cell #(
  parameter int unsigned J = 0
) (
  input  logic                 clk_i,
  input  pscd_pkg::cell_ctrl_t ctrl_i,
  input  pscd_pkg::cost_t      left_i,
  input  pscd_pkg::cost_t      right_i,
  output pscd_pkg::cost_t      left_o,
  output pscd_pkg::cost_t      right_o
);
  import pscd_pkg::*;

  localparam need_t JIdx = need_t'(J);
  localparam cost_t TwoJ = cost_t'(2 * J);

  cost_t row_q, row_d;
  cost_t l_q, l_d;
  cost_t r_q, r_d;
  logic  in_range;
  cost_t masked;
  logic [CostW:0] sum;

  always_comb begin
    in_range = (JIdx >= ctrl_i.lo) && (JIdx <= ctrl_i.limit);
    masked   = in_range ? row_q : CostSat;
    sum      = {1'b0, cost_min(l_q, r_q)} + {1'b0, TwoJ};
    row_d    = row_q;
    l_d      = l_q;
    r_d      = r_q;
    case (ctrl_i.mode)
      CELL_LOAD: begin
        l_d = masked;
        r_d = masked;
      end
      CELL_RELAX: begin
        l_d = cost_min(l_q, sat_inc(left_i));
        r_d = cost_min(r_q, sat_inc(right_i));
      end
      CELL_COMMIT: begin
        if (in_range) begin
          row_d = sum[CostW] ? CostSat : sum[CostW-1:0];
        end
      end
      CELL_FIRST: begin
        if (in_range) begin
          row_d = TwoJ;
        end
      end
      CELL_MLOAD: r_d = masked;
      CELL_MIN:   r_d = cost_min(r_q, right_i);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    l_q   <= l_d;
    r_q   <= r_d;
  end

  assign left_o  = l_q;
  assign right_o = r_q;

endmodule

@@ src/provisioning_switch_cost_dp_core.sv @@
// ----------------------------------------------------------------------------
// provisioning_switch_cost_dp_core
// Optimal and greedy container provisioning cost over a sample sequence.
// ----------------------------------------------------------------------------
// One sample at a time. Each sample passes a 20-step and a 40-step serial
// divider side by side, then MAX_COUNT relaxation steps along the row of
// cells; the last sample of a sequence without overflow then also takes the
// final minimum, which walks the same chain toward count zero. A first
// sample or one that overflows the limit skips the relaxation. The result
// waits in an output register while the next sample is taken; a second
// result stalls the block until the first one is transferred.
module provisioning_switch_cost_dp_core #(
  parameter int unsigned MAX_COUNT = 63
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pscd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pscd_pkg::CfgW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [19:0]                 cpu_sample_i,
  input  logic [39:0]                 mem_sample_i,
  input  logic                        last_sample_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [31:0]                 best_cost_doubled_o,
  output logic [31:0]                 greedy_cost_doubled_o,
  output logic                        infeasible_o
);
  import pscd_pkg::*;

  localparam int unsigned Cells = MAX_COUNT + 1;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DIV    = 9'b000000010,
    S_NEED   = 9'b000000100,
    S_DP     = 9'b000001000,
    S_RELAX  = 9'b000010000,
    S_COMMIT = 9'b000100000,
    S_FIN    = 9'b001000000,
    S_MIN    = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [19:0] cpu_step_q, cpu_floor_q;
  logic [39:0] mem_step_q, mem_floor_q;
  logic [5:0]  max_count_q;

  need_t prev_q, prev_d, need_q, need_d, limit_q, limit_d, cnt_q, cnt_d;
  cost_t greedy_q, greedy_d;
  logic  first_q, first_d, ovf_q, ovf_d, last_q, last_d;
  logic  out_valid_q, out_valid_d;
  cost_t best_q, best_d, ogreedy_q, ogreedy_d;
  logic  oinf_q, oinf_d;

  logic        accept;
  logic [19:0] dc;
  logic [39:0] dm;
  logic        cpu_busy, mem_busy;
  need_t       cpu_need, mem_need;
  need_t       sw;
  logic [CostW+1:0] gsum;
  need_t       max_lim;

  cell_ctrl_t ctrl;
  cost_t      l_out [Cells];
  cost_t      r_out [Cells];

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign dc = (cpu_sample_i > cpu_floor_q) ? cpu_sample_i - cpu_floor_q : '0;
  assign dm = (mem_sample_i > mem_floor_q) ? mem_sample_i - mem_floor_q : '0;
  assign max_lim = ({2'b00, max_count_q} < need_t'(MAX_COUNT)) ?
                   {2'b00, max_count_q} : need_t'(MAX_COUNT);

  pscd_div #(.W(20)) u_cpu_div (
    .clk_i, .rst_ni, .start_i(accept), .dividend_i(dc), .divisor_i(cpu_step_q),
    .busy_o(cpu_busy), .need_o(cpu_need)
  );

  pscd_div #(.W(40)) u_mem_div (
    .clk_i, .rst_ni, .start_i(accept), .dividend_i(dm), .divisor_i(mem_step_q),
    .busy_o(mem_busy), .need_o(mem_need)
  );

  for (genvar g = 0; g < Cells; g++) begin : g_cell
    cost_t lin, rin;
    if (g == 0) begin : g_lft
      assign lin = CostSat;
    end else begin : g_lmid
      assign lin = l_out[g-1];
    end
    if (g == Cells - 1) begin : g_rgt
      assign rin = CostSat;
    end else begin : g_rmid
      assign rin = r_out[g+1];
    end
    pscd_cell #(.J(g)) u_cell (
      .clk_i, .ctrl_i(ctrl), .left_i(lin), .right_i(rin),
      .left_o(l_out[g]), .right_o(r_out[g])
    );
  end

  always_comb begin
    ctrl.mode  = CELL_HOLD;
    ctrl.lo    = need_q;
    ctrl.limit = limit_q;
    case (state_q)
      S_DP: begin
        if (!ovf_q) begin
          ctrl.mode = first_q ? CELL_FIRST : CELL_LOAD;
          ctrl.lo   = first_q ? need_q : prev_q;
        end
      end
      S_RELAX:  ctrl.mode = CELL_RELAX;
      S_COMMIT: ctrl.mode = CELL_COMMIT;
      S_FIN:    ctrl.mode = (last_q && !ovf_q) ? CELL_MLOAD : CELL_HOLD;
      S_MIN:    ctrl.mode = CELL_MIN;
      default:  ctrl.mode = CELL_HOLD;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    prev_d      = prev_q;
    need_d      = need_q;
    limit_d     = limit_q;
    cnt_d       = cnt_q;
    greedy_d    = greedy_q;
    first_d     = first_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    best_d      = best_q;
    ogreedy_d   = ogreedy_q;
    oinf_d      = oinf_q;
    sw          = (need_q > prev_q) ? need_q - prev_q : prev_q - need_q;
    gsum        = {2'b00, greedy_q} + {(CostW+2-NeedW-1)'(0), need_q, 1'b0}
                + {(CostW+2-NeedW)'(0), sw};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          last_d  = last_sample_i;
          if (first_q) begin
            limit_d = max_lim;
          end
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (!cpu_busy && !mem_busy) begin
          need_d  = (cpu_need > mem_need) ? cpu_need : mem_need;
          state_d = S_NEED;
        end
      end
      S_NEED: begin
        greedy_d = (gsum > {2'b00, CostSat}) ? CostSat : gsum[CostW-1:0];
        if (need_q > limit_q) begin
          ovf_d = 1'b1;
        end
        state_d = S_DP;
      end
      S_DP: begin
        cnt_d   = '0;
        state_d = (ovf_q || first_q) ? S_FIN : S_RELAX;
      end
      S_RELAX: begin
        cnt_d = cnt_q + need_t'(1);
        if (cnt_q == need_t'(MAX_COUNT - 1)) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: state_d = S_FIN;
      S_FIN: begin
        prev_d  = need_q;
        first_d = 1'b0;
        cnt_d   = '0;
        if (!last_q) begin
          state_d = S_IDLE;
        end else begin
          state_d = ovf_q ? S_OUT : S_MIN;
        end
      end
      S_MIN: begin
        cnt_d = cnt_q + need_t'(1);
        if (cnt_q == need_t'(MAX_COUNT - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          best_d      = ovf_q ? CostSat : r_out[0];
          ogreedy_d   = greedy_q;
          oinf_d      = ovf_q;
          prev_d      = '0;
          greedy_d    = '0;
          first_d     = 1'b1;
          ovf_d       = 1'b0;
          limit_d     = '0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_q      <= '0;
      need_q      <= '0;
      limit_q     <= '0;
      cnt_q       <= '0;
      greedy_q    <= '0;
      first_q     <= 1'b1;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cpu_step_q  <= 20'd1000;
      mem_step_q  <= 40'd1073741824;
      cpu_floor_q <= 20'd5000;
      mem_floor_q <= 40'd1020054732;
      max_count_q <= 6'd63;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      need_q      <= need_d;
      limit_q     <= limit_d;
      cnt_q       <= cnt_d;
      greedy_q    <= greedy_d;
      first_q     <= first_d;
      ovf_q       <= ovf_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgCpuStep:  cpu_step_q  <= cfg_data_i[19:0];
          CfgMemStep:  mem_step_q  <= cfg_data_i;
          CfgCpuFloor: cpu_floor_q <= cfg_data_i[19:0];
          CfgMemFloor: mem_floor_q <= cfg_data_i;
          CfgMaxCount: max_count_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_q    <= best_d;
    ogreedy_q <= ogreedy_d;
    oinf_q    <= oinf_d;
  end

  assign out_valid_o           = out_valid_q;
  assign best_cost_doubled_o   = best_q;
  assign greedy_cost_doubled_o = ogreedy_q;
  assign infeasible_o          = oinf_q;

`ifndef ASSERT_OFF
  a_inf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && infeasible_o |-> best_cost_doubled_o == CostSat)
    else $error("infeasible result without saturated cost");
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result raised outside output state");
  a_relax_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RELAX || state_q == S_MIN |-> cnt_q < need_t'(MAX_COUNT))
    else $error("chain step count out of range");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_NEED |-> !cpu_busy && !mem_busy)
    else $error("need taken while divider busy");
`endif

endmodule

@@ tb/sv/provisioning_switch_cost_dp_core_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// provisioning_switch_cost_dp_core_checker
// Watches the sample and result channels, predicts the optimal and greedy
// provisioning costs of each sequence and compares every result transfer.
// ----------------------------------------------------------------------------
module provisioning_switch_cost_dp_core_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [39:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [19:0] cpu_sample_i,
  input  logic [39:0] mem_sample_i,
  input  logic        last_sample_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] best_i,
  input  logic [31:0] greedy_i,
  input  logic        infeasible_i,
  output int          errors_o,
  output int          pending_o
);
  import pscd_pkg::*;

  typedef struct packed {
    logic [31:0] best;
    logic [31:0] greedy;
    logic        infeasible;
  } cost_result_t;

  localparam int unsigned MaxCnt = 63;

  logic [19:0] cpu_step_q, cpu_floor_q;
  logic [39:0] mem_step_q, mem_floor_q;
  logic [5:0]  max_count_q;
  logic [31:0] row_q [0:MaxCnt];
  int unsigned prev_need_q, greedy_q, limit_q;
  bit          first_q, ovf_q;
  cost_result_t expected_results[$];

  function automatic longint unsigned sat32(longint unsigned v);
    return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
  endfunction

  function automatic longint unsigned part_need(longint unsigned s, longint unsigned f,
                                                longint unsigned st);
    longint unsigned d;
    d = (s > f) ? s - f : 0;
    if (st == 0) return 255;
    return d / st + 1;
  endfunction

  task automatic advance_sequence(input logic [19:0] cpu, input logic [39:0] mem,
                                  input logic last);
    longint unsigned nc, nm, n, bestv, c, d;
    int unsigned need, sw;
    logic [31:0] nxt [0:MaxCnt];
    cost_result_t r;
    nc = part_need(cpu, cpu_floor_q, cpu_step_q);
    nm = part_need(mem, mem_floor_q, mem_step_q);
    n = (nc > nm) ? nc : nm;
    need = 32'((n > 255) ? 255 : n);
    if (first_q) limit_q = (max_count_q < MaxCnt) ? max_count_q : MaxCnt;
    sw = (need > prev_need_q) ? need - prev_need_q : prev_need_q - need;
    greedy_q = 32'(sat32(64'(greedy_q) + 2 * need + sw));
    if (need > limit_q) ovf_q = 1;
    if (!ovf_q) begin
      if (first_q) begin
        for (int j = need; j <= limit_q; j++) row_q[j] = 2 * j;
      end else begin
        for (int j = need; j <= limit_q; j++) begin
          bestv = 64'hFFFF_FFFF;
          for (int k = prev_need_q; k <= limit_q; k++) begin
            d = (k > j) ? k - j : j - k;
            c = 64'(row_q[k]) + d + 2 * j;
            if (c < bestv) bestv = c;
          end
          nxt[j] = 32'(sat32(bestv));
        end
        for (int j = need; j <= limit_q; j++) row_q[j] = nxt[j];
      end
    end
    prev_need_q = need;
    first_q = 0;
    if (last) begin
      bestv = 64'hFFFF_FFFF;
      if (!ovf_q)
        for (int j = need; j <= limit_q; j++) if (row_q[j] < bestv) bestv = row_q[j];
      r.best = bestv[31:0];
      r.greedy = greedy_q;
      r.infeasible = ovf_q;
      expected_results.push_back(r);
      prev_need_q = 0; greedy_q = 0; first_q = 1; ovf_q = 0; limit_q = 0;
    end
  endtask

  assign pending_o = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    cost_result_t e;
    int nerr;
    nerr = 0;
    if (!rst_ni) begin
      cpu_step_q <= 20'd1000; mem_step_q <= 40'd1073741824;
      cpu_floor_q <= 20'd5000; mem_floor_q <= 40'd1020054732; max_count_q <= 6'd63;
      prev_need_q = 0; greedy_q = 0; first_q = 1; ovf_q = 0; limit_q = 0;
      errors_o <= 0;
      expected_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgCpuStep:  cpu_step_q  <= cfg_data_i[19:0];
          CfgMemStep:  mem_step_q  <= cfg_data_i;
          CfgCpuFloor: cpu_floor_q <= cfg_data_i[19:0];
          CfgMemFloor: mem_floor_q <= cfg_data_i;
          CfgMaxCount: max_count_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer");
          nerr++;
        end else begin
          e = expected_results.pop_front();
          if (best_i !== e.best) begin
            $error("best_cost_doubled expected %0d actual %0d", e.best, best_i);
            nerr++;
          end
          if (greedy_i !== e.greedy) begin
            $error("greedy_cost_doubled expected %0d actual %0d", e.greedy, greedy_i);
            nerr++;
          end
          if (infeasible_i !== e.infeasible) begin
            $error("infeasible expected %0d actual %0d", e.infeasible, infeasible_i);
            nerr++;
          end
        end
      end
      if (nerr != 0) errors_o <= errors_o + nerr;
      if (in_valid_i && in_ready_i) advance_sequence(cpu_sample_i, mem_sample_i, last_sample_i);
    end
  end
endmodule

@@ tb/sv/provisioning_switch_cost_dp_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// provisioning_switch_cost_dp_core_tb
// Drives sample sequences under several sizing settings with random gaps and
// stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module provisioning_switch_cost_dp_core_tb;
  import pscd_pkg::*;

  localparam int Watchdog = 20000;

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [2:0] cfg_idx_i = '0;
  logic [39:0] cfg_data_i = '0;
  logic in_valid_i = 0, in_ready_o, last_sample_i = 0;
  logic [19:0] cpu_sample_i = '0;
  logic [39:0] mem_sample_i = '0;
  logic out_valid_o, out_ready_i = 0, infeasible_o;
  logic [31:0] best_cost_doubled_o, greedy_cost_doubled_o;
  int errors, pending, idle_cycles;
  bit hold_off, sender_done;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  provisioning_switch_cost_dp_core uut (.*);

  provisioning_switch_cost_dp_core_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .cpu_sample_i, .mem_sample_i, .last_sample_i,
    .out_valid_i(out_valid_o), .out_ready_i, .best_i(best_cost_doubled_o),
    .greedy_i(greedy_cost_doubled_o), .infeasible_i(infeasible_o),
    .errors_o(errors), .pending_o(pending));

  task automatic write_reg(input logic [2:0] idx, input logic [39:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic send_sample(input logic [19:0] c, input logic [39:0] m, input logic l,
                             input bit gaps);
    @(negedge clk_i);
    if (gaps) repeat ($urandom_range(0, 14)) @(negedge clk_i);
    in_valid_i <= 1; cpu_sample_i <= c; mem_sample_i <= m; last_sample_i <= l;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i <= 0;
  endtask

  task automatic drain;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic apply_setting(input int s);
    case (s)
      0: begin
        write_reg(CfgCpuStep, 1000); write_reg(CfgMemStep, 40'd1073741824);
        write_reg(CfgCpuFloor, 5000); write_reg(CfgMemFloor, 40'd1020054732);
        write_reg(CfgMaxCount, 63);
      end
      1: begin
        write_reg(CfgCpuStep, 1); write_reg(CfgMemStep, 1);
        write_reg(CfgCpuFloor, 0); write_reg(CfgMemFloor, 0); write_reg(CfgMaxCount, 1);
      end
      2: begin
        write_reg(CfgCpuStep, 20'hFFFFF); write_reg(CfgMemStep, 40'hFF_FFFF_FFFF);
        write_reg(CfgCpuFloor, 20'hFFFFF); write_reg(CfgMemFloor, 40'hFF_FFFF_FFFF);
        write_reg(CfgMaxCount, 32);
      end
      3: begin
        write_reg(CfgCpuStep, 16000); write_reg(CfgMemStep, 40'd16_000_000_000);
        write_reg(CfgCpuFloor, 2000); write_reg(CfgMemFloor, 40'd500_000_000);
        write_reg(CfgMaxCount, 63);
      end
      default: begin
        write_reg(CfgCpuStep, $urandom_range(8000, 60000));
        write_reg(CfgMemStep, {8'd0, $urandom_range(32'h1000_0000, 32'hFFFF_FFFF)});
        write_reg(CfgCpuFloor, $urandom_range(0, 20'hFFFFF));
        write_reg(CfgMemFloor, 40'({$urandom_range(0, 3), $urandom()}));
        write_reg(CfgMaxCount, $urandom_range(1, 63));
      end
    endcase
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    apply_setting(0);
    send_sample(0, 0, 1, 0);
    send_sample(20'hFFFFF, 40'hFF_FFFF_FFFF, 1, 0);
    send_sample(9000, 40'd3_000_000_000, 0, 0);
    send_sample(30000, 40'd1_000_000_000, 0, 0);
    send_sample(6000, 40'd9_000_000_000, 1, 0);
    drain();
    write_reg(CfgCpuStep, 0);
    send_sample(100, 0, 1, 0);
    drain();
    apply_setting(1);
    send_sample(0, 0, 0, 0);
    send_sample(1, 0, 1, 0);
    send_sample(0, 0, 0, 0);
    while (!in_ready_o) @(negedge clk_i);
    write_reg(CfgMaxCount, 20);
    send_sample(0, 0, 1, 0);
    drain();
    apply_setting(2);
    send_sample(20'hFFFFF, 40'hFF_FFFF_FFFF, 0, 0);
    send_sample(0, 0, 1, 0);
    drain();
    write_reg(CfgMemStep, 0);
    send_sample(0, 0, 1, 0);
    drain();
    for (int phase = 0; phase < 11; phase++) begin
      apply_setting(phase < 3 ? phase + 1 : 4);
      for (int n = 0; n < 150; n++) begin
        logic [19:0] c;
        logic [39:0] m;
        if ($urandom_range(0, 9) == 0) begin
          c = 20'($urandom()); m = 40'({$urandom(), $urandom()});
        end else begin
          c = 20'($urandom_range(0, 600000));
          m = 40'({$urandom_range(0, 60), $urandom()});
        end
        send_sample(c, m, ($urandom_range(0, 5) == 0) || n == 149, phase % 3 != 2);
      end
      drain();
    end
    sender_done = 1;
  end

  initial begin
    int unsigned w;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (out_valid_o && !hold_off) begin
        w = $urandom_range(0, 14);
        repeat (w) @(negedge clk_i);
        while (hold_off) @(negedge clk_i);
        out_ready_i <= 1;
        @(posedge clk_i);
        @(negedge clk_i);
        out_ready_i <= 0;
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    repeat (4000) @(negedge clk_i);
    hold_off = 1;
    repeat (3000) @(negedge clk_i);
    hold_off = 0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    fork
      wait (sender_done && pending == 0);
      wait (idle_cycles >= Watchdog);
    join_any
    if (idle_cycles >= Watchdog) begin
      $display("provisioning_switch_cost_dp_core_tb: errors");
      $finish;
    end else begin
      repeat (400) @(negedge clk_i);
      if (errors == 0 && pending == 0) begin
        $display("provisioning_switch_cost_dp_core_tb: clean");
      end else begin
        $display("provisioning_switch_cost_dp_core_tb: errors");
      end
      $finish;
    end
  end
endmodule
